// File: src/url_form_decoder_macros.svh
`ifndef URL_FORM_DECODER_MACROS_SVH
`define URL_FORM_DECODER_MACROS_SVH

// same-cycle implication
`define UFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ufd_pkg.sv
package ufd_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_NAME_END  = 2'd1,
		KIND_VALUE_END = 2'd2,
		KIND_TEXT_END  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		kind_t       kind;
		logic [15:0] pair_count;
		logic        last;
	} res_t;

	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] ALPHA_OFS = 8'd55;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	function automatic logic [7:0] hex_val(input logic [7:0] c);
		hex_val = (c >= CH_UPA) ? (c - ALPHA_OFS) : (c - CH_ZERO);
	endfunction

endpackage

// File: src/ufd_raw_if.sv
interface ufd_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// File: src/ufd_dec_if.sv
interface ufd_dec_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [1:0]  kind;
	logic [15:0] pair_count;
	logic        last;

	modport source (output valid, output out_byte, output kind, output pair_count,
		output last, input ready);
	modport sink (input valid, input out_byte, input kind, input pair_count,
		input last, output ready);
endinterface

// File: src/url_form_decoder.sv
// Streaming form-urlencoded decoder. Raw bytes are taken on raw; a zero byte
// ends the text. Each byte gives zero, one or two result items on decoded: '+' becomes a
// space, %XY becomes one byte, %0D%0A becomes a single newline, '=' and '&' give name-end
// and value-end markers, and the zero byte gives a text-end item with the saturating
// count of raw '=' bytes. An accepted byte is held in the input stage register, and its
// results pass through the result queue. Input is taken back to back at one byte per cycle
// as long as results are drained; a byte with two results pushes both into the four-entry
// result queue at once, and the queue stops input when fewer than two slots are free.
`include "url_form_decoder_macros.svh"

module url_form_decoder (
	input  logic     clk,
	input  logic     arst_n,
	ufd_raw_if.sink  raw,
	ufd_dec_if.source decoded
);

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_PCT      = 3'd1,
		PH_DIGIT    = 3'd2,
		PH_CR       = 3'd3,
		PH_CR_PCT   = 3'd4,
		PH_CR_ZERO  = 3'd5
	} phase_t;

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	phase_t                        phase_q;
	logic [7:0]                    pv_q;
	logic [15:0]                   eq_q;

	logic                          advance;
	logic [ufd_pkg::RES_CNT_W-1:0] fifo_count;
	ufd_pkg::res_t                 fifo_head;
	logic                          pop;

	phase_t        phase_d;
	logic [7:0]    pv_d;
	logic [15:0]   eq_d;
	logic [15:0]   eq_inc;
	logic [7:0]    hv;
	logic [7:0]    esc;
	logic          pre_v;
	logic          main_v;
	ufd_pkg::res_t pre_r;
	ufd_pkg::res_t main_r;
	ufd_pkg::res_t out0;
	ufd_pkg::res_t out1;
	logic [1:0]    push_n;

	assign advance   = valid_s1 && (fifo_count <= ufd_pkg::RES_CNT_W'(2));
	assign raw.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.valid && raw.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1 <= raw.in_byte;
		end
	end

	always_comb begin
		hv     = ufd_pkg::hex_val(byte_s1);
		esc    = {pv_q[3:0], 4'b0000} + hv;
		eq_inc = (byte_s1 == ufd_pkg::CH_EQ && eq_q != ufd_pkg::COUNT_MAX) ?
			eq_q + 16'd1 : eq_q;
		phase_d = phase_q;
		pv_d    = pv_q;
		eq_d    = eq_inc;
		pre_v   = 1'b0;
		main_v  = 1'b0;
		pre_r   = '{out_byte: ufd_pkg::CH_CR, kind: ufd_pkg::KIND_BYTE,
			pair_count: 16'd0, last: 1'b0};
		main_r  = '{out_byte: byte_s1, kind: ufd_pkg::KIND_BYTE,
			pair_count: 16'd0, last: 1'b0};

		if (byte_s1 == ufd_pkg::CH_NUL) begin
			pre_v  = (phase_q == PH_CR) || (phase_q == PH_CR_PCT) || (phase_q == PH_CR_ZERO);
			main_v = 1'b1;
			main_r.out_byte   = 8'd0;
			main_r.kind       = ufd_pkg::KIND_TEXT_END;
			main_r.pair_count = eq_inc;
			phase_d = PH_IDLE;
			pv_d    = 8'd0;
			eq_d    = 16'd0;
		end else begin
			case (phase_q)
				PH_PCT: begin
					pv_d    = hv;
					phase_d = PH_DIGIT;
				end
				PH_DIGIT: begin
					if (esc == ufd_pkg::CH_CR) begin
						phase_d = PH_CR;
					end else begin
						main_v          = 1'b1;
						main_r.out_byte = esc;
						phase_d         = PH_IDLE;
					end
				end
				PH_CR_PCT: begin
					if (byte_s1 == ufd_pkg::CH_ZERO) begin
						phase_d = PH_CR_ZERO;
					end else begin
						pre_v   = 1'b1;
						pv_d    = hv;
						phase_d = PH_DIGIT;
					end
				end
				PH_CR_ZERO: begin
					pre_v = 1'b1;
					if (byte_s1 == ufd_pkg::CH_UPA) begin
						pre_v           = 1'b0;
						main_v          = 1'b1;
						main_r.out_byte = ufd_pkg::CH_LF;
						phase_d         = PH_IDLE;
					end else if (hv == ufd_pkg::CH_CR) begin
						phase_d = PH_CR;
					end else begin
						main_v          = 1'b1;
						main_r.out_byte = hv;
						phase_d         = PH_IDLE;
					end
				end
				default: begin
					// idle, or held carriage return
					if (phase_q == PH_CR && byte_s1 == ufd_pkg::CH_PCT) begin
						phase_d = PH_CR_PCT;
					end else begin
						pre_v   = (phase_q == PH_CR);
						phase_d = PH_IDLE;
						if (byte_s1 == ufd_pkg::CH_PCT) begin
							phase_d = PH_PCT;
						end else if (byte_s1 == ufd_pkg::CH_PLUS) begin
							main_v          = 1'b1;
							main_r.out_byte = ufd_pkg::CH_SPACE;
						end else if (byte_s1 == ufd_pkg::CH_EQ) begin
							main_v          = 1'b1;
							main_r.out_byte = 8'd0;
							main_r.kind     = ufd_pkg::KIND_NAME_END;
						end else if (byte_s1 == ufd_pkg::CH_AMP) begin
							main_v          = 1'b1;
							main_r.out_byte = 8'd0;
							main_r.kind     = ufd_pkg::KIND_VALUE_END;
						end else begin
							main_v = 1'b1;
						end
					end
				end
			endcase
		end

		pre_r.last  = !main_v;
		main_r.last = 1'b1;
		out0 = pre_v ? pre_r : main_r;
		out1 = main_r;
		if (!advance) begin
			push_n = 2'd0;
		end else begin
			push_n = {1'b0, pre_v} + {1'b0, main_v};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pv_q    <= 8'd0;
			eq_q    <= 16'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			pv_q    <= pv_d;
			eq_q    <= eq_d;
		end
	end

	assign pop = decoded.valid && decoded.ready;

	ufd_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_n  (push_n),
		.push_d0 (out0),
		.push_d1 (out1),
		.pop     (pop),
		.count   (fifo_count),
		.head    (fifo_head)
	);

	assign decoded.valid      = (fifo_count != '0);
	assign decoded.out_byte   = fifo_head.out_byte;
	assign decoded.kind       = fifo_head.kind;
	assign decoded.pair_count = fifo_head.pair_count;
	assign decoded.last       = fifo_head.last;

	`UFD_ASSERT_NOW(a_fifo_bound, clk, arst_n, 1'b1,
		fifo_count <= ufd_pkg::RES_CNT_W'(ufd_pkg::RES_DEPTH), "result queue overflow")
	`UFD_ASSERT_NEXT(a_text_end_clears, clk, arst_n, advance && byte_s1 == ufd_pkg::CH_NUL,
		phase_q == PH_IDLE && eq_q == 16'd0, "state not cleared after text end")
	`UFD_ASSERT_NEXT(a_second_follows, clk, arst_n, pop && !decoded.last,
		decoded.valid, "item without last not followed by another")
	`UFD_ASSERT_NEXT(a_accept_loads, clk, arst_n, raw.valid && raw.ready,
		valid_s1, "accepted item not held in input stage")

endmodule

// File: src/ufd_result_fifo.sv
module ufd_result_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [1:0]                     push_n,
	input  ufd_pkg::res_t                  push_d0,
	input  ufd_pkg::res_t                  push_d1,
	input  logic                           pop,
	output logic [ufd_pkg::RES_CNT_W-1:0]  count,
	output ufd_pkg::res_t                  head
);

	ufd_pkg::res_t                  mem_q [ufd_pkg::RES_DEPTH];
	logic [ufd_pkg::RES_PTR_W-1:0]  wp_q;
	logic [ufd_pkg::RES_PTR_W-1:0]  rp_q;
	logic [ufd_pkg::RES_CNT_W-1:0]  count_q;
	logic [ufd_pkg::RES_PTR_W-1:0]  wp_plus1;

	assign wp_plus1 = wp_q + {{(ufd_pkg::RES_PTR_W-1){1'b0}}, 1'b1};
	assign count    = count_q;
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + ufd_pkg::RES_PTR_W'(push_n);
			rp_q    <= rp_q + ufd_pkg::RES_PTR_W'(pop);
			count_q <= count_q + ufd_pkg::RES_CNT_W'(push_n) - ufd_pkg::RES_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_plus1] <= push_d1;
		end
	end

endmodule

// File: dv/url_form_decoder_checker.sv
`timescale 1ns / 100ps

module url_form_decoder_checker (
	input  logic clk,
	input  logic arst_n,
	ufd_raw_if   raw,
	ufd_dec_if   decoded,
	output int   fail_count,
	output int   pending
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PCT,
		PH_DIGIT,
		PH_CR,
		PH_CR_PCT,
		PH_CR_ZERO
	} phase_e;

	phase_e          ph;
	logic [7:0]      first_nib;
	logic [15:0]     eq_count;
	ufd_pkg::res_t   decoded_q[$];
	ufd_pkg::res_t   held_res;
	ufd_pkg::res_t   want;
	bit              have_res;
	int              errs;
	int              n_out;

	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		logic [7:0] ofs;
		ofs = (c >= ufd_pkg::CH_UPA) ? ufd_pkg::ALPHA_OFS : ufd_pkg::CH_ZERO;
		return c - ofs;
	endfunction

	task automatic report(input string what);
		errs++;
		if (errs <= 50)
			$display("[%0t] decoded item mismatch: %s", $time, what);
	endtask

	// one result is kept back so the final one of a byte can be flagged
	task automatic emit(input logic [7:0] b, input ufd_pkg::kind_t k,
		input logic [15:0] cnt);
		if (have_res)
			decoded_q.push_back(held_res);
		held_res.out_byte = b;
		held_res.kind = k;
		held_res.pair_count = cnt;
		held_res.last = 1'b0;
		have_res = 1'b1;
	endtask

	task automatic plain(input logic [7:0] b);
		ph = PH_IDLE;
		case (b)
			ufd_pkg::CH_PCT:  ph = PH_PCT;
			ufd_pkg::CH_PLUS: emit(ufd_pkg::CH_SPACE, ufd_pkg::KIND_BYTE, 16'd0);
			ufd_pkg::CH_EQ:   emit(8'd0, ufd_pkg::KIND_NAME_END, 16'd0);
			ufd_pkg::CH_AMP:  emit(8'd0, ufd_pkg::KIND_VALUE_END, 16'd0);
			default: emit(b, ufd_pkg::KIND_BYTE, 16'd0);
		endcase
	endtask

	task automatic close_escape(input logic [7:0] d);
		if (d == ufd_pkg::CH_CR) begin
			ph = PH_CR;
		end else begin
			emit(d, ufd_pkg::KIND_BYTE, 16'd0);
			ph = PH_IDLE;
		end
	endtask

	task automatic take_byte(input logic [7:0] b);
		have_res = 1'b0;
		if (b == ufd_pkg::CH_EQ && eq_count != ufd_pkg::COUNT_MAX)
			eq_count++;
		if (b == ufd_pkg::CH_NUL) begin
			if (ph == PH_CR || ph == PH_CR_PCT || ph == PH_CR_ZERO)
				emit(ufd_pkg::CH_CR, ufd_pkg::KIND_BYTE, 16'd0);
			emit(8'd0, ufd_pkg::KIND_TEXT_END, eq_count);
			ph = PH_IDLE;
			first_nib = 8'd0;
			eq_count = 16'd0;
		end else begin
			case (ph)
				PH_PCT: begin
					first_nib = nibble_of(b);
					ph = PH_DIGIT;
				end
				PH_DIGIT: close_escape({first_nib[3:0], 4'h0} + nibble_of(b));
				PH_CR: begin
					if (b == ufd_pkg::CH_PCT) begin
						ph = PH_CR_PCT;
					end else begin
						emit(ufd_pkg::CH_CR, ufd_pkg::KIND_BYTE, 16'd0);
						plain(b);
					end
				end
				PH_CR_PCT: begin
					if (b == ufd_pkg::CH_ZERO) begin
						ph = PH_CR_ZERO;
					end else begin
						emit(ufd_pkg::CH_CR, ufd_pkg::KIND_BYTE, 16'd0);
						first_nib = nibble_of(b);
						ph = PH_DIGIT;
					end
				end
				PH_CR_ZERO: begin
					if (b == ufd_pkg::CH_UPA) begin
						emit(ufd_pkg::CH_LF, ufd_pkg::KIND_BYTE, 16'd0);
						ph = PH_IDLE;
					end else begin
						emit(ufd_pkg::CH_CR, ufd_pkg::KIND_BYTE, 16'd0);
						// leading zero digit adds nothing
						close_escape(nibble_of(b));
					end
				end
				default: plain(b);
			endcase
		end
		if (have_res) begin
			held_res.last = 1'b1;
			decoded_q.push_back(held_res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_IDLE;
			first_nib = 8'd0;
			eq_count = 16'd0;
			decoded_q.delete();
		end else begin
			if (raw.valid && raw.ready)
				take_byte(raw.in_byte);
			if (decoded.valid && decoded.ready) begin
				n_out++;
				if (decoded_q.size() == 0) begin
					report($sformatf("item %0d arrived with nothing expected", n_out));
				end else begin
					want = decoded_q.pop_front();
					if (decoded.out_byte !== want.out_byte)
						report($sformatf("item %0d out_byte %h, expected %h", n_out,
							decoded.out_byte, want.out_byte));
					if (decoded.kind !== want.kind)
						report($sformatf("item %0d kind %0d, expected %0d", n_out,
							decoded.kind, want.kind));
					if (decoded.pair_count !== want.pair_count)
						report($sformatf("item %0d pair_count %0d, expected %0d", n_out,
							decoded.pair_count, want.pair_count));
					if (decoded.last !== want.last)
						report($sformatf("item %0d last %b, expected %b", n_out,
							decoded.last, want.last));
				end
			end
		end
		fail_count <= errs;
		pending <= decoded_q.size();
	end

endmodule

// File: dv/tb_url_form_decoder.sv
`timescale 1ns / 100ps

module tb_url_form_decoder;

	localparam logic [7:0] CH_UPD = 8'h44;
	localparam logic [7:0] CH_LOWA = 8'h61;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm;
	int   sent;
	int   hold_reqs;
	int   hold_done;
	int   hold_left;
	int   fail_count;
	int   pending;
	int   base;
	int   w;

	ufd_raw_if raw_ch();
	ufd_dec_if dec_ch();

	url_form_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_ch),
		.decoded(dec_ch)
	);

	url_form_decoder_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_ch),
		.decoded(dec_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #4 clk = ~clk;

	initial begin
		#4_000_000;
		$display("[url_form_decoder] ERROR");
		$finish;
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		dec_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				dec_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_reqs != hold_done) begin
				hold_done++;
				hold_left = 400;
				dec_ch.ready <= 1'b0;
			end else begin
				dec_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
			end
		end
	end

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return ufd_pkg::CH_ZERO + 8'(v);
		// lower case now and then
		return (($urandom_range(0, 3) == 0) ? CH_LOWA : ufd_pkg::CH_UPA) + 8'(v - 10);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 37) begin
			raw_ch.valid <= 1'b0;
			@(posedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.in_byte <= b;
		do
			@(posedge clk);
		while (raw_ch.ready !== 1'b1);
		sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		raw_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic send_random_text();
		logic [7:0] txt[$];
		int n;
		n = $urandom_range(1, 12);
		repeat (n) begin
			case ($urandom_range(0, 15))
				0, 1, 2, 3: txt.push_back(8'($urandom_range(1, 127)));
				4: txt.push_back(ufd_pkg::CH_PLUS);
				5: txt.push_back(ufd_pkg::CH_EQ);
				6: txt.push_back(ufd_pkg::CH_AMP);
				7, 8, 9: txt = {txt, ufd_pkg::CH_PCT, hex_char(), hex_char()};
				10, 11: txt = {txt, ufd_pkg::CH_PCT, ufd_pkg::CH_ZERO, CH_UPD,
					ufd_pkg::CH_PCT, ufd_pkg::CH_ZERO, ufd_pkg::CH_UPA};
				12: begin
					// held carriage return, then a broken pair
					txt = {txt, ufd_pkg::CH_PCT, ufd_pkg::CH_ZERO, CH_UPD};
					case ($urandom_range(0, 2))
						0: txt.push_back(8'($urandom_range(1, 255)));
						1: txt = {txt, ufd_pkg::CH_PCT, 8'($urandom_range(1, 255))};
						default: txt = {txt, ufd_pkg::CH_PCT, ufd_pkg::CH_ZERO,
							8'($urandom_range(1, 255))};
					endcase
				end
				13: begin
					txt.push_back(ufd_pkg::CH_PCT);
					if ($urandom_range(0, 1) == 1)
						txt.push_back(hex_char());
				end
				14: txt = {txt, ufd_pkg::CH_PCT, 8'($urandom_range(1, 255)),
					8'($urandom_range(1, 255))};
				default: txt.push_back(8'($urandom_range(128, 255)));
			endcase
		end
		foreach (txt[i])
			send_byte(txt[i]);
		send_byte(ufd_pkg::CH_NUL);
	endtask

	initial begin
		raw_ch.valid <= 1'b0;
		raw_ch.in_byte <= ufd_pkg::CH_NUL;
		calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(ufd_pkg::CH_NUL);
		send_str("+=&");
		send_byte(8'hFF);
		send_str("%0D%0A%=&%0D%0D%Z1%0D%0");
		send_byte(ufd_pkg::CH_NUL);
		send_str("%4");
		send_byte(ufd_pkg::CH_NUL);
		wait_drained();

		while (sent < 400)
			send_random_text();
		hold_reqs++;
		repeat (4) send_random_text();
		wait_drained();

		// no idling here: a long run of '=' bytes
		calm = 1'b1;
		send_str("%=1");
		repeat (100) send_byte(ufd_pkg::CH_EQ);
		send_byte(ufd_pkg::CH_NUL);
		calm = 1'b0;

		base = sent;
		while (sent - base < 530)
			send_random_text();
		raw_ch.valid <= 1'b0;

		for (w = 0; w < 20000 && pending != 0; w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[url_form_decoder] OK");
		else
			$display("[url_form_decoder] ERROR");
		$finish;
	end

endmodule
